// ===== hw/rtl/ffba_pkg.sv =====
// Shared types and constants for the first-fit block allocator.
`default_nettype none

package ffba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 64;

  localparam int unsigned ADDR_W   = 20;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned HDR_W    = 7;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = 20'h10000;
  localparam logic [HDR_W-1:0]  HEADER_RST     = 7'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER     = 1'b1;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd4;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] cap;
    logic              free;
  } entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ffba_table.sv =====
// Block table RAM: one write port, one registered read port.
`default_nettype none

module ffba_table import ffba_pkg::*; #(
  parameter int unsigned Depth = MAX_BLOCKS_DEF,
  localparam int unsigned IdxW = $clog2(Depth)
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [IdxW-1:0] waddr_i,
  input  wire entry_t          wdata_i,
  input  wire logic [IdxW-1:0] raddr_i,
  output      entry_t          rdata_o
);

  entry_t mem [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/first_fit_block_allocator_unit.sv =====
// First-fit block allocator: scan sequencer, heap break and result register.
//
// Each request (allocate or release) is taken only while the unit is idle and yields exactly one
// result. The table of blocks sits in a single-port-read RAM that is walked in address order one
// entry per cycle, with the read pipelined so the compare of entry k overlaps the fetch of k+1.
// A request that hits entry k ends its scan there; a scan that misses walks every block, and
// an allocate then appends a new block past the heap break. Zero-size allocates and null
// releases skip the scan. Results are held in an output register, so a finished result may
// wait on a stall while the next request is already being worked. Config writes act at once.
`default_nettype none

module first_fit_block_allocator_unit import ffba_pkg::*; #(
  parameter int unsigned MaxBlocks = MAX_BLOCKS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ADDR_W-1:0]    cfg_wdata_i,

  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire logic                 action_i,
  input  wire logic [SIZE_W-1:0]    request_size_i,
  input  wire logic [ADDR_W-1:0]    release_address_i,

  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      logic [STATUS_W-1:0]  status_o,
  output      logic [ADDR_W-1:0]    data_address_o,
  output      logic                 was_reused_o
);

  localparam int unsigned IdxW = $clog2(MaxBlocks);
  localparam int unsigned CntW = $clog2(MaxBlocks + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPEND,
    S_OUT
  } state_e;

  state_e state_q;

  logic [ADDR_W-1:0] limit_q;
  logic [HDR_W-1:0]  hdr_q;

  logic              act_q;
  logic [SIZE_W-1:0] size_q;
  logic [ADDR_W-1:0] addr_q;

  logic [CntW-1:0]   idx_q;
  logic [CntW-1:0]   pidx_q;
  logic              pend_q;
  logic [CntW-1:0]   count_q;
  logic [ADDR_W-1:0] brk_q;

  logic [STATUS_W-1:0] rs_st_q;
  logic [ADDR_W-1:0]   rs_addr_q;
  logic                rs_reu_q;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_st_q;
  logic [ADDR_W-1:0]   out_addr_q;
  logic                out_reu_q;

  entry_t          ent;
  entry_t          wdata;
  logic            we;
  logic [IdxW-1:0] waddr;
  logic            hit;
  logic            last;
  logic            more;
  logic [CntW-1:0] pidx_inc;
  logic [ADDR_W:0] base_sum;
  logic [ADDR_W:0] new_brk;
  logic            full;
  logic            over;

  ffba_table #(
    .Depth(MaxBlocks)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(idx_q[IdxW-1:0]),
    .rdata_o(ent)
  );

  assign pidx_inc = pidx_q + CntW'(1);
  assign last     = pend_q && (pidx_inc == count_q);
  assign more     = (idx_q != count_q);
  assign hit      = pend_q && ((act_q == ACT_ALLOC) ? (ent.free && (ent.cap >= size_q))
                                                    : (ent.base == addr_q));

  assign base_sum = {1'b0, brk_q} + (ADDR_W+1)'(hdr_q);
  assign new_brk  = base_sum + (ADDR_W+1)'(size_q);
  assign full     = (count_q == CntW'(MaxBlocks));
  assign over     = (new_brk > {1'b0, limit_q});

  always_comb begin
    we    = 1'b0;
    waddr = pidx_q[IdxW-1:0];
    wdata = ent;
    if (state_q == S_SCAN && hit) begin
      we         = 1'b1;
      wdata.free = (act_q == ACT_RELEASE);
    end else if (state_q == S_APPEND && !full && !over) begin
      we         = 1'b1;
      waddr      = count_q[IdxW-1:0];
      wdata.base = base_sum[ADDR_W-1:0];
      wdata.cap  = size_q;
      wdata.free = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= HEAP_LIMIT_RST;
      hdr_q   <= HEADER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEAP_LIMIT: limit_q <= cfg_wdata_i;
        CFG_HEADER:     hdr_q   <= cfg_wdata_i[HDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= ACT_ALLOC;
      size_q      <= '0;
      addr_q      <= '0;
      idx_q       <= '0;
      pidx_q      <= '0;
      pend_q      <= 1'b0;
      count_q     <= '0;
      brk_q       <= '0;
      rs_st_q     <= ST_OK;
      rs_addr_q   <= '0;
      rs_reu_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_st_q    <= ST_OK;
      out_addr_q  <= '0;
      out_reu_q   <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            act_q     <= action_i;
            size_q    <= request_size_i;
            addr_q    <= release_address_i;
            idx_q     <= '0;
            pend_q    <= 1'b0;
            rs_addr_q <= '0;
            rs_reu_q  <= 1'b0;
            if ((action_i == ACT_ALLOC && request_size_i == '0) ||
                (action_i == ACT_RELEASE && release_address_i == '0)) begin
              rs_st_q <= ST_IGNORED;
              state_q <= S_OUT;
            end else if (count_q == '0) begin
              if (action_i == ACT_ALLOC) begin
                rs_st_q <= ST_OK;
                state_q <= S_APPEND;
              end else begin
                rs_st_q <= ST_UNKNOWN;
                state_q <= S_OUT;
              end
            end else begin
              rs_st_q <= ST_OK;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          pend_q <= more && !hit && !last;
          pidx_q <= idx_q;
          if (more) begin
            idx_q <= idx_q + CntW'(1);
          end
          if (hit) begin
            rs_st_q  <= ST_OK;
            if (act_q == ACT_ALLOC) begin
              rs_addr_q <= ent.base;
              rs_reu_q  <= 1'b1;
            end
            state_q <= S_OUT;
          end else if (last) begin
            if (act_q == ACT_ALLOC) begin
              state_q <= S_APPEND;
            end else begin
              rs_st_q <= ST_UNKNOWN;
              state_q <= S_OUT;
            end
          end
        end
        S_APPEND: begin
          if (full) begin
            rs_st_q <= ST_TABLE_FULL;
          end else if (over) begin
            rs_st_q <= ST_EXHAUSTED;
          end else begin
            rs_st_q   <= ST_OK;
            rs_addr_q <= base_sum[ADDR_W-1:0];
            count_q   <= count_q + CntW'(1);
            brk_q     <= new_brk[ADDR_W-1:0];
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_st_q    <= rs_st_q;
            out_addr_q  <= rs_addr_q;
            out_reu_q   <= rs_reu_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign data_address_o = out_addr_q;
  assign was_reused_o   = out_reu_q;

endmodule

`default_nettype wire
